// ----- design/evad_pkg.sv -----
// Package: types, constants and register map of the energy VAD endpoint detector.
`timescale 1ns / 1ps
package evad_pkg;

  // Register indexes (byte address = 4 * index)
  localparam int unsigned NumRegs = 8;
  localparam int unsigned AddrW   = 5;
  localparam logic [2:0] REG_FLOOR_INIT   = 3'd0;
  localparam logic [2:0] REG_CALIB_TICKS  = 3'd1;
  localparam logic [2:0] REG_START_MIN    = 3'd2;
  localparam logic [2:0] REG_SILENCE_MIN  = 3'd3;
  localparam logic [2:0] REG_LOUD_NEEDED  = 3'd4;
  localparam logic [2:0] REG_SILENT_NEED  = 3'd5;
  localparam logic [2:0] REG_MIN_TICKS    = 3'd6;
  localparam logic [2:0] REG_MAX_TICKS    = 3'd7;

  // Stop reasons
  localparam logic [1:0] END_NONE   = 2'd0;
  localparam logic [1:0] END_SPEECH = 2'd1;
  localparam logic [1:0] END_LIMIT  = 2'd2;

  // Q.8 gains and integer offsets
  localparam logic [9:0] GAIN_START   = 10'd614;
  localparam logic [8:0] GAIN_SILENCE = 9'd422;
  localparam logic [7:0] GAIN_KEEP    = 8'd220;
  localparam logic [5:0] GAIN_NEW     = 6'd36;
  localparam logic [6:0] OFFSET_START   = 7'd120;
  localparam logic [6:0] OFFSET_SILENCE = 7'd80;

  // Register reset values
  localparam logic [15:0] RST_FLOOR_INIT  = 16'd180;
  localparam logic [3:0]  RST_CALIB_TICKS = 4'd2;
  localparam logic [15:0] RST_START_MIN   = 16'd380;
  localparam logic [15:0] RST_SILENCE_MIN = 16'd300;
  localparam logic [3:0]  RST_LOUD_NEEDED = 4'd2;
  localparam logic [5:0]  RST_SILENT_NEED = 6'd7;
  localparam logic [7:0]  RST_MIN_TICKS   = 8'd10;
  localparam logic [7:0]  RST_MAX_TICKS   = 8'd60;

  typedef struct packed {
    logic [15:0] noise_floor_init;
    logic [3:0]  calib_ticks;
    logic [15:0] start_level_min;
    logic [15:0] silence_level_min;
    logic [3:0]  loud_ticks_needed;
    logic [5:0]  silent_ticks_needed;
    logic [7:0]  min_session_ticks;
    logic [7:0]  max_session_ticks;
  } evad_cfg_t;

  typedef struct packed {
    logic [7:0]  tick_counter;
    logic [3:0]  loud_run;
    logic [5:0]  silent_run;
    logic [23:0] noise_floor_fx;
    logic        speech_seen;
    logic        session_done;
    logic [1:0]  end_code;
  } evad_state_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] level;
    logic        level_valid;
  } evad_req_t;

endpackage

// ----- design/evad_req_if.sv -----
// Request channel: command, level and level-valid flag.
`timescale 1ns / 1ps
interface evad_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] level;
  logic        level_valid;

  modport source (output valid, cmd, level, level_valid, input ready);
  modport sink   (input valid, cmd, level, level_valid, output ready);
endinterface

// ----- design/evad_rsp_if.sv -----
// Response channel: session status after each request.
`timescale 1ns / 1ps
interface evad_rsp_if;
  logic        valid;
  logic        ready;
  logic        heard_speech;
  logic        stop;
  logic [1:0]  end_reason;
  logic [15:0] floor_now;
  logic [7:0]  tick_count;

  modport source (output valid, heard_speech, stop, end_reason, floor_now, tick_count,
                  input ready);
  modport sink   (input valid, heard_speech, stop, end_reason, floor_now, tick_count,
                  output ready);
endinterface

// ----- design/evad_step.sv -----
// Next-state logic for one request: calibration, thresholds, floor adaptation, stop checks.
`timescale 1ns / 1ps
module evad_step
  import evad_pkg::*;
(
  input  evad_cfg_t   cfg_i,
  input  evad_state_t state_i,
  input  evad_req_t   req_i,
  output evad_state_t state_o
);

  logic [7:0]  tick_inc;
  logic [23:0] lv;
  logic [24:0] calib_sum;
  logic [33:0] start_prod;
  logic [32:0] silence_prod;
  logic [26:0] start_gain_thr;
  logic [26:0] silence_gain_thr;
  logic [26:0] start_min_thr;
  logic [26:0] silence_min_thr;
  logic [26:0] start_thr;
  logic [26:0] silence_thr;
  logic [31:0] adapt_sum;
  logic        loud;
  logic        silent;
  logic        ended;
  logic        hard;
  evad_state_t nxt;

  assign tick_inc  = (state_i.tick_counter != 8'hFF) ? state_i.tick_counter + 8'd1
                                                     : state_i.tick_counter;
  assign lv        = {req_i.level, 8'h00};
  assign calib_sum = {1'b0, state_i.noise_floor_fx} + {1'b0, lv};

  // floor * gain, truncated back to Q.8, plus offset in Q.8
  assign start_prod       = 34'(state_i.noise_floor_fx) * 34'(GAIN_START);
  assign silence_prod     = 33'(state_i.noise_floor_fx) * 33'(GAIN_SILENCE);
  assign start_gain_thr   = 27'(start_prod[33:8]) + 27'({OFFSET_START, 8'h00});
  assign silence_gain_thr = 27'(silence_prod[32:8]) + 27'({OFFSET_SILENCE, 8'h00});
  assign start_min_thr    = 27'({cfg_i.start_level_min, 8'h00});
  assign silence_min_thr  = 27'({cfg_i.silence_level_min, 8'h00});
  assign start_thr   = (start_min_thr > start_gain_thr) ? start_min_thr : start_gain_thr;
  assign silence_thr = (silence_min_thr > silence_gain_thr) ? silence_min_thr
                                                            : silence_gain_thr;
  assign loud   = 27'(lv) > start_thr;
  assign silent = 27'(lv) < silence_thr;

  // sum stays below 2^32 since the gains add up to 256
  assign adapt_sum = 32'(state_i.noise_floor_fx) * 32'(GAIN_KEEP)
                   + 32'(lv) * 32'(GAIN_NEW);

  always_comb begin
    nxt   = state_i;
    ended = 1'b0;
    hard  = 1'b0;
    if (req_i.cmd) begin
      nxt.tick_counter   = '0;
      nxt.loud_run       = '0;
      nxt.silent_run     = '0;
      nxt.noise_floor_fx = {cfg_i.noise_floor_init, 8'h00};
      nxt.speech_seen    = 1'b0;
      nxt.session_done   = 1'b0;
      nxt.end_code       = END_NONE;
    end else if (!state_i.session_done) begin
      nxt.tick_counter = tick_inc;
      if (req_i.level_valid) begin
        if (tick_inc <= {4'h0, cfg_i.calib_ticks}) begin
          nxt.noise_floor_fx = calib_sum[24:1];
        end else if (!state_i.speech_seen) begin
          if (loud) begin
            if (state_i.loud_run != 4'hF) begin
              nxt.loud_run = state_i.loud_run + 4'd1;
            end
          end else begin
            nxt.loud_run       = '0;
            nxt.noise_floor_fx = adapt_sum[31:8];
          end
          if (nxt.loud_run >= cfg_i.loud_ticks_needed) begin
            nxt.speech_seen = 1'b1;
            nxt.silent_run  = '0;
          end
        end else begin
          if (silent) begin
            if (state_i.silent_run != 6'h3F) begin
              nxt.silent_run = state_i.silent_run + 6'd1;
            end
          end else begin
            nxt.silent_run = '0;
          end
        end
      end
      ended = nxt.speech_seen && (nxt.silent_run >= cfg_i.silent_ticks_needed)
           && (nxt.tick_counter >= cfg_i.min_session_ticks);
      hard  = nxt.tick_counter >= cfg_i.max_session_ticks;
      if (ended || hard) begin
        nxt.session_done = 1'b1;
        nxt.end_code     = ended ? END_SPEECH : END_LIMIT;
      end
    end
  end

  assign state_o = nxt;

endmodule

// ----- design/energy_vad_endpoint_detector_core.sv -----
// Top level of the energy VAD endpoint detector: register file, request and result stages.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------------
//  req_i   | in        | valid / ready      | cmd, level, level_valid
//  rsp_o   | out       | valid / ready      | heard_speech, stop, end_reason, floor_now,
//          |           |                    | tick_count
//  APB     | in        | psel/penable/pready| 8 registers at byte address 4*index
//
// A request is registered, then evaluated against the session state into the result
// register; one request per cycle is sustained while rsp_o.ready stays high.
// The session state updates when a request moves into the result register.
// Reset puts the state as if a session had just started. A stalled result holds the stage
// while one more request waits in the input register.
`timescale 1ns / 1ps
module energy_vad_endpoint_detector_core
  import evad_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  evad_req_if.sink          req_i,
  evad_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  evad_cfg_t   cfg_q;
  evad_state_t state_q;
  evad_state_t state_d;
  evad_req_t   req_q;
  logic        req_vld_q;
  evad_state_t rsp_q;
  logic        rsp_vld_q;
  logic        advance;
  logic        req_take;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_floor_init    <= RST_FLOOR_INIT;
      cfg_q.calib_ticks         <= RST_CALIB_TICKS;
      cfg_q.start_level_min     <= RST_START_MIN;
      cfg_q.silence_level_min   <= RST_SILENCE_MIN;
      cfg_q.loud_ticks_needed   <= RST_LOUD_NEEDED;
      cfg_q.silent_ticks_needed <= RST_SILENT_NEED;
      cfg_q.min_session_ticks   <= RST_MIN_TICKS;
      cfg_q.max_session_ticks   <= RST_MAX_TICKS;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FLOOR_INIT:  cfg_q.noise_floor_init    <= pwdata[15:0];
        REG_CALIB_TICKS: cfg_q.calib_ticks         <= pwdata[3:0];
        REG_START_MIN:   cfg_q.start_level_min     <= pwdata[15:0];
        REG_SILENCE_MIN: cfg_q.silence_level_min   <= pwdata[15:0];
        REG_LOUD_NEEDED: cfg_q.loud_ticks_needed   <= pwdata[3:0];
        REG_SILENT_NEED: cfg_q.silent_ticks_needed <= pwdata[5:0];
        REG_MIN_TICKS:   cfg_q.min_session_ticks   <= pwdata[7:0];
        REG_MAX_TICKS:   cfg_q.max_session_ticks   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FLOOR_INIT:  prdata = 32'(cfg_q.noise_floor_init);
      REG_CALIB_TICKS: prdata = 32'(cfg_q.calib_ticks);
      REG_START_MIN:   prdata = 32'(cfg_q.start_level_min);
      REG_SILENCE_MIN: prdata = 32'(cfg_q.silence_level_min);
      REG_LOUD_NEEDED: prdata = 32'(cfg_q.loud_ticks_needed);
      REG_SILENT_NEED: prdata = 32'(cfg_q.silent_ticks_needed);
      REG_MIN_TICKS:   prdata = 32'(cfg_q.min_session_ticks);
      REG_MAX_TICKS:   prdata = 32'(cfg_q.max_session_ticks);
      default:         prdata = '0;
    endcase
  end

  // ---------------- request / result stages ----------------
  assign advance     = req_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !req_vld_q || advance;
  assign req_take    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (req_take) begin
        req_vld_q <= 1'b1;
      end else if (advance) begin
        req_vld_q <= 1'b0;
      end
      if (advance) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_q.cmd         <= req_i.cmd;
      req_q.level       <= req_i.level;
      req_q.level_valid <= req_i.level_valid;
    end
    if (advance) begin
      rsp_q <= state_d;
    end
  end

  evad_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .req_i   (req_q),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.tick_counter   <= '0;
      state_q.loud_run       <= '0;
      state_q.silent_run     <= '0;
      state_q.noise_floor_fx <= {RST_FLOOR_INIT, 8'h00};
      state_q.speech_seen    <= 1'b0;
      state_q.session_done   <= 1'b0;
      state_q.end_code       <= END_NONE;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.heard_speech = rsp_q.speech_seen;
  assign rsp_o.stop         = rsp_q.session_done;
  assign rsp_o.end_reason   = rsp_q.end_code;
  assign rsp_o.floor_now    = rsp_q.noise_floor_fx[23:8];
  assign rsp_o.tick_count   = rsp_q.tick_counter;

endmodule
